### rtl/core/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants for the interval sort and merge block.
// ----------------------------------------------------------------------------
package ism_pkg;

    // Default sizes of the sorting chain and of the stored coordinates.
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int COORD_BITS_DEF    = 16;

    // Width of the coordinate fields on the ports.
    localparam int FIELD_BITS = 16;

    // Sequencer states.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins_en;   // insert the incoming word at its sorted place
        logic drain;    // move every entry one cell toward the head
    } t_cell_ctl;

endpackage

### rtl/core/ism_cell.sv
// ----------------------------------------------------------------------------
// ism_cell
// One cell of the insertion sorting chain: holds one interval and hands it
// to its neighbor on insertion or drain.
// ----------------------------------------------------------------------------
module ism_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                   i_clk,
    input  ism_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_occupied,
    input  logic                   i_is_tail,
    input  logic [COORD_BITS-1:0]  i_new_start,
    input  logic [COORD_BITS-1:0]  i_new_end,
    input  logic                   i_left_gt,
    input  logic [COORD_BITS-1:0]  i_left_start,
    input  logic [COORD_BITS-1:0]  i_left_end,
    input  logic [COORD_BITS-1:0]  i_right_start,
    input  logic [COORD_BITS-1:0]  i_right_end,
    output logic                   o_gt,
    output logic [COORD_BITS-1:0]  o_span_start,
    output logic [COORD_BITS-1:0]  o_span_end
);
    import ism_pkg::*;

    logic [COORD_BITS-1:0] r_start;
    logic [COORD_BITS-1:0] r_end;
    logic [COORD_BITS-1:0] n_start;
    logic [COORD_BITS-1:0] n_end;

    // The held interval sorts strictly after the incoming one.
    always_comb begin
        if (r_start != i_new_start) begin
            o_gt = i_occupied && (r_start > i_new_start);
        end else begin
            o_gt = i_occupied && (r_end > i_new_end);
        end
    end

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        if (i_ctl.drain) begin
            n_start = i_right_start;
            n_end   = i_right_end;
        end else if (i_ctl.ins_en) begin
            if (i_left_gt) begin
                n_start = i_left_start;
                n_end   = i_left_end;
            end else if (o_gt || i_is_tail) begin
                n_start = i_new_start;
                n_end   = i_new_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_span_start = r_start;
    assign o_span_end   = r_end;

endmodule

### rtl/core/interval_sort_and_merge.sv
// ----------------------------------------------------------------------------
// interval_sort_and_merge
// Sorts incoming intervals in a chain of cells and, on the final word of a
// set, drains the chain and emits the union of the intervals in order.
// Throughput: while loading, one word is accepted every cycle (busy low).
// A set drains after its final word with busy high, the chain moving one cell
// a cycle toward the head; each result is registered from its merge decision.
// Reset (synchronous, active low) empties the chain and clears overflow.
// ----------------------------------------------------------------------------
module interval_sort_and_merge #(
    parameter int MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = ism_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ism_pkg::FIELD_BITS-1:0]  i_span_start,
    input  logic [ism_pkg::FIELD_BITS-1:0]  i_span_end,
    input  logic                            i_final_item,
    output logic                            o_valid,
    output logic [ism_pkg::FIELD_BITS-1:0]  o_merged_start,
    output logic [ism_pkg::FIELD_BITS-1:0]  o_merged_end,
    output logic                            o_run_last,
    output logic                            o_overflowed
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    // Sequencer and bookkeeping. During loading r_count is the number of
    // occupied cells; during drain it counts the entries still in the chain.
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_dropped;
    logic               n_dropped;
    logic               r_first;
    logic               n_first;

    // Running merged interval.
    logic [COORD_BITS-1:0] r_cur_l;
    logic [COORD_BITS-1:0] r_cur_r;
    logic [COORD_BITS-1:0] n_cur_l;
    logic [COORD_BITS-1:0] n_cur_r;

    // Registered result word.
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [COORD_BITS-1:0] r_out_start;
    logic [COORD_BITS-1:0] n_out_start;
    logic [COORD_BITS-1:0] r_out_end;
    logic [COORD_BITS-1:0] n_out_end;
    logic                  r_out_last;
    logic                  n_out_last;
    logic                  r_out_ovf;
    logic                  n_out_ovf;

    // Chain wiring.
    t_cell_ctl             cell_ctl;
    logic                  accept;
    logic                  room;
    logic [COORD_BITS-1:0] new_start;
    logic [COORD_BITS-1:0] new_end;
    logic [MAX_INTERVALS-1:0]  gt;
    logic [COORD_BITS-1:0]     cell_start [MAX_INTERVALS];
    logic [COORD_BITS-1:0]     cell_end   [MAX_INTERVALS];

    // Coordinates are kept at COORD_BITS bits inside the chain.
    assign new_start = COORD_BITS'(i_span_start);
    assign new_end   = COORD_BITS'(i_span_end);

    assign busy   = (r_state == ST_DRAIN);
    assign accept = start && !busy;
    assign room   = (r_count < CNT_W'(MAX_INTERVALS));

    assign cell_ctl.ins_en = accept && room;
    assign cell_ctl.drain  = busy && (r_count != '0);

    // The chain: each cell sees the incoming word, its left neighbor for
    // the insertion shift and its right neighbor for the drain shift.
    // Cell 0 is the head, where the smallest interval sits.
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
        logic                  left_gt;
        logic [COORD_BITS-1:0] left_start;
        logic [COORD_BITS-1:0] left_end;
        logic [COORD_BITS-1:0] right_start;
        logic [COORD_BITS-1:0] right_end;

        if (g == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_start = cell_start[g];
            assign left_end   = cell_end[g];
        end else begin : g_body
            assign left_gt    = gt[g-1];
            assign left_start = cell_start[g-1];
            assign left_end   = cell_end[g-1];
        end

        if (g == MAX_INTERVALS - 1) begin : g_tail
            assign right_start = cell_start[g];
            assign right_end   = cell_end[g];
        end else begin : g_inner
            assign right_start = cell_start[g+1];
            assign right_end   = cell_end[g+1];
        end

        ism_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (CNT_W'(g) < r_count),
            .i_is_tail     (CNT_W'(g) == r_count),
            .i_new_start   (new_start),
            .i_new_end     (new_end),
            .i_left_gt     (left_gt),
            .i_left_start  (left_start),
            .i_left_end    (left_end),
            .i_right_start (right_start),
            .i_right_end   (right_end),
            .o_gt          (gt[g]),
            .o_span_start  (cell_start[g]),
            .o_span_end    (cell_end[g])
        );
    end

    // Sequencer. While loading, each accepted word is inserted into the
    // chain unless it is full, in which case the word is dropped and the
    // overflow flag set. The final word switches to drain: each cycle the
    // head interval is taken and the chain moves one cell toward the head.
    // An interval that starts past the running end closes the current run,
    // which is emitted; otherwise it only extends the end. Once the chain
    // is empty the open run is emitted as the last word of the set and the
    // count and overflow flag clear for the next set.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_first     = r_first;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_out_valid = 1'b0;
        n_out_start = r_out_start;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (room) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_final_item) begin
                        n_state = ST_DRAIN;
                        n_first = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                    n_first = 1'b0;
                    if (r_first) begin
                        n_cur_l = cell_start[0];
                        n_cur_r = cell_end[0];
                    end else if (cell_start[0] > r_cur_r) begin
                        n_out_valid = 1'b1;
                        n_out_start = r_cur_l;
                        n_out_end   = r_cur_r;
                        n_out_last  = 1'b0;
                        n_out_ovf   = r_dropped;
                        n_cur_l     = cell_start[0];
                        n_cur_r     = cell_end[0];
                    end else if (cell_end[0] > r_cur_r) begin
                        n_cur_r = cell_end[0];
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_out_start = r_cur_l;
                    n_out_end   = r_cur_r;
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_dropped;
                    n_dropped   = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_l     <= n_cur_l;
        r_cur_r     <= n_cur_r;
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_valid        = r_out_valid;
    assign o_merged_start = FIELD_BITS'(r_out_start);
    assign o_merged_end   = FIELD_BITS'(r_out_end);
    assign o_run_last     = r_out_last;
    assign o_overflowed   = r_out_ovf;

    // The chain never holds more intervals than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_INTERVALS))
        else $error("interval count exceeds chain length");

    // Results come only out of a drain.
    a_valid_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_DRAIN)
        else $error("result word outside drain");

    // The last word of a set leaves the block empty and ready to load.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_last) |-> (r_count == '0 && r_state == ST_LOAD && !r_dropped))
        else $error("state not cleared after last word");

    // A final word always starts a drain of a non-empty chain.
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final_item) |=> (r_state == ST_DRAIN && r_count != '0 && r_first))
        else $error("final word did not start a drain");

endmodule

### test/interval_sort_and_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_sort_and_merge_checker
// Watches the word and result channels of the interval merger. It keeps its
// own sorted copy of each set, builds the expected merged runs when the final
// word of a set is accepted, and checks every result strobe against them.
// ----------------------------------------------------------------------------
module interval_sort_and_merge_checker #(
    parameter int MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = ism_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [ism_pkg::FIELD_BITS-1:0] i_span_start,
    input  logic [ism_pkg::FIELD_BITS-1:0] i_span_end,
    input  logic                           i_final_item,
    input  logic                           i_valid,
    input  logic [ism_pkg::FIELD_BITS-1:0] i_merged_start,
    input  logic [ism_pkg::FIELD_BITS-1:0] i_merged_end,
    input  logic                           i_run_last,
    input  logic                           i_overflowed,
    output int                             o_mismatches,
    output int                             o_pending
);
    import ism_pkg::*;

    localparam logic [31:0] COORD_MASK = 32'hFFFF_FFFF >> (32 - COORD_BITS);

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
    } t_span;

    typedef struct {
        logic [FIELD_BITS-1:0] lo;
        logic [FIELD_BITS-1:0] hi;
        logic                  last;
        logic                  ovf;
    } t_merged_run;

    t_span       sorted_spans[$];
    logic        spans_dropped = 1'b0;
    t_merged_run awaited_runs[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string detail);
        $display("%0t ns: mismatch: %s", $time, detail);
        o_mismatches++;
    endtask

    function automatic bit orders_after(t_span a, t_span b);
        if (a.lo != b.lo)
            return a.lo > b.lo;
        return a.hi > b.hi;
    endfunction

    function automatic t_merged_run to_run(t_span sp, logic last);
        t_merged_run run;
        run.lo   = sp.lo[FIELD_BITS-1:0];
        run.hi   = sp.hi[FIELD_BITS-1:0];
        run.last = last;
        run.ovf  = spans_dropped;
        return run;
    endfunction

    // Insert one word into the sorted copy; on the final word, fold the set
    // into merged runs. Touching spans join, and the run end only grows.
    task automatic absorb_word(input logic [FIELD_BITS-1:0] s, input logic [FIELD_BITS-1:0] e,
                               input logic fin);
        t_span incoming;
        t_span cur;
        int    pos;
        incoming.lo = 32'(s) & COORD_MASK;
        incoming.hi = 32'(e) & COORD_MASK;
        if (sorted_spans.size() < MAX_INTERVALS) begin
            pos = sorted_spans.size();
            while (pos > 0 && orders_after(sorted_spans[pos-1], incoming))
                pos--;
            sorted_spans.insert(pos, incoming);
        end else begin
            spans_dropped = 1'b1;
        end
        if (fin) begin
            cur = sorted_spans[0];
            for (int i = 1; i < sorted_spans.size(); i++) begin
                if (sorted_spans[i].lo > cur.hi) begin
                    awaited_runs.insert(awaited_runs.size(), to_run(cur, 1'b0));
                    cur = sorted_spans[i];
                end else if (sorted_spans[i].hi > cur.hi) begin
                    cur.hi = sorted_spans[i].hi;
                end
            end
            awaited_runs.insert(awaited_runs.size(), to_run(cur, 1'b1));
            sorted_spans.delete();
            spans_dropped = 1'b0;
        end
    endtask

    task automatic check_run();
        t_merged_run want;
        if (awaited_runs.size() == 0) begin
            report_mismatch($sformatf("merged word %0h..%0h with nothing pending",
                                      i_merged_start, i_merged_end));
        end else begin
            want = awaited_runs.pop_front();
            if (i_merged_start !== want.lo)
                report_mismatch($sformatf("merged_start got %0h, expected %0h",
                                          i_merged_start, want.lo));
            if (i_merged_end !== want.hi)
                report_mismatch($sformatf("merged_end got %0h, expected %0h",
                                          i_merged_end, want.hi));
            if (i_run_last !== want.last)
                report_mismatch($sformatf("run_last got %b, expected %b",
                                          i_run_last, want.last));
            if (i_overflowed !== want.ovf)
                report_mismatch($sformatf("overflowed got %b, expected %b",
                                          i_overflowed, want.ovf));
        end
    endtask

    // Everything is sampled at the rising edge, before the block's own
    // updates for that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid)
                check_run();
            if (i_start && !i_busy)
                absorb_word(i_span_start, i_span_end, i_final_item);
        end
        o_pending = awaited_runs.size();
    end

endmodule

### test/interval_sort_and_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_sort_and_merge_tb
// Drives sets of intervals into the merger, first a handful of hand-picked
// sets and then random sets of random size and spread, some with random gaps
// between words. A checker beside the block predicts and compares the merged
// runs; this module only makes stimulus and decides the verdict.
// ----------------------------------------------------------------------------
module interval_sort_and_merge_tb;
    import ism_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [FIELD_BITS-1:0] i_span_start;
    logic [FIELD_BITS-1:0] i_span_end;
    logic                  i_final_item;
    logic                  o_valid;
    logic [FIELD_BITS-1:0] o_merged_start;
    logic [FIELD_BITS-1:0] o_merged_end;
    logic                  o_run_last;
    logic                  o_overflowed;

    int mismatches;
    int pending;
    int random_words = 0;

    interval_sort_and_merge u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_span_start   (i_span_start),
        .i_span_end     (i_span_end),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .o_merged_start (o_merged_start),
        .o_merged_end   (o_merged_end),
        .o_run_last     (o_run_last),
        .o_overflowed   (o_overflowed)
    );

    interval_sort_and_merge_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_span_start   (i_span_start),
        .i_span_end     (i_span_end),
        .i_final_item   (i_final_item),
        .i_valid        (o_valid),
        .i_merged_start (o_merged_start),
        .i_merged_end   (o_merged_end),
        .i_run_last     (o_run_last),
        .i_overflowed   (o_overflowed),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The slowest correct run stays well under a few hundred microseconds,
    // even with every word delayed by the longest gap and every set draining
    // a full chain. This bound leaves a wide margin over that.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Offer one word and hold it until the block takes it. A gap lowers start
    // first; with no gap start stays high straight into the next word, so it
    // never gets two assignments in one step.
    task automatic send_span(input logic [FIELD_BITS-1:0] s, input logic [FIELD_BITS-1:0] e,
                             input logic fin, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_span_start <= s;
        i_span_end   <= e;
        i_final_item <= fin;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop offering words until every merged run of the sets sent so far has
    // come out. The extra edge lets the checker book the last final word.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // One random set. The style picks the spread: spans over the whole range
    // (which toggles every coordinate bit), spans clustered around a base so
    // that they overlap, touch and nest, or clustered spans where some have
    // their end below their start. A paced set gets a random gap before each
    // word; an unpaced one streams back to back.
    task automatic send_random_set(input int words);
        int                    style;
        bit                    paced;
        int                    base;
        int                    lo;
        int                    hi;
        int                    tmp;
        style = $urandom_range(0, 2);
        paced = $urandom_range(0, 1);
        base  = $urandom_range(0, 65535);
        for (int k = 0; k < words; k++) begin
            if (style == 0) begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
            end else begin
                lo = base + $urandom_range(0, 400);
                hi = lo + $urandom_range(0, 60);
                if (lo > 65535) lo = 65535;
                if (hi > 65535) hi = 65535;
            end
            // Most spans are well formed; a few keep their end below start.
            if ((lo > hi) != (style == 2 && $urandom_range(0, 3) == 0)) begin
                if ($urandom_range(0, 7) != 0 || style != 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            send_span(lo[FIELD_BITS-1:0], hi[FIELD_BITS-1:0], k == words - 1,
                      paced ? $urandom_range(0, 15) : 0);
            random_words++;
        end
    endtask

    initial begin
        int words;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_span_start <= '0;
        i_span_end   <= '0;
        i_final_item <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A set of a single interval, at both ends of the range.
        send_span(16'h0000, 16'h0000, 1'b1, 0);
        send_span(16'hFFFF, 16'hFFFF, 1'b1, 3);
        // A short span nested inside the full range.
        send_span(16'h0000, 16'hFFFF, 1'b0, 0);
        send_span(16'd10, 16'd20, 1'b1, 0);
        // Touching spans join; a span one past the end starts a new run.
        send_span(16'd5, 16'd10, 1'b0, 2);
        send_span(16'd10, 16'd15, 1'b0, 0);
        send_span(16'd16, 16'd20, 1'b1, 1);
        // Spans arriving out of order, with equal starts.
        send_span(16'd100, 16'd200, 1'b0, 0);
        send_span(16'd50, 16'd60, 1'b0, 0);
        send_span(16'd50, 16'd55, 1'b0, 5);
        send_span(16'd300, 16'd300, 1'b1, 0);
        // Ends below starts are kept as given and never shrink a run.
        send_span(16'd40, 16'd30, 1'b0, 0);
        send_span(16'd35, 16'd50, 1'b0, 0);
        send_span(16'd60, 16'd10, 1'b1, 0);
        // Identical spans.
        send_span(16'd7, 16'd9, 1'b0, 0);
        send_span(16'd7, 16'd9, 1'b1, 0);
        // Alternating bit patterns in two touching spans, which join into one run.
        send_span(16'h5555, 16'hAAAA, 1'b0, 0);
        send_span(16'hAAAA, 16'hFFFF, 1'b1, 0);
        hold_until_drained();

        // The first random set fills the chain and has its final word
        // dropped, so the set goes out with the overflow flag set.
        send_random_set(MAX_INTERVALS_DEF + 1);
        while (random_words < 230) begin
            if ($urandom_range(0, 9) == 0)
                words = $urandom_range(MAX_INTERVALS_DEF - 4, MAX_INTERVALS_DEF + 6);
            else
                words = $urandom_range(1, 12);
            send_random_set(words);
            if ($urandom_range(0, 7) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (MAX_INTERVALS_DEF + 8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
